/* src/fse_pkg.sv */
// Package for the frequency sort engine: shared widths, the sequencer state
// type and the compare result struct. No dependencies.
package fse_pkg;

    localparam int VALUE_W       = 32;
    localparam int MAX_ITEMS_DEF = 64;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CNT_FETCH,
        ST_CNT_LATCH,
        ST_CNT_SCAN,
        ST_RNK_FETCH,
        ST_RNK_LATCH,
        ST_RNK_SCAN,
        ST_EMIT_READ,
        ST_EMIT_LOAD,
        ST_EMIT_WAIT
    } state_t;

    // Result of comparing one scanned entry against the held entry.
    typedef struct packed {
        logic val_eq;       // values are equal
        logic scan_first;   // scanned entry orders strictly before the held one
    } cmp_t;

endpackage

/* src/frequency_sort_engine_core.sv */
// Top level of the frequency sort engine: load sequencer, count and rank
// passes over the shared compare unit, and the output stage.
// Depends on fse_pkg, fse_ram and fse_cmp.

// Values stream in on the slave side, one item per cycle while the block is
// idle, and are stored in order until the item marked by tlast arrives; items
// beyond MAX_ITEMS are dropped and m_tuser reports that on every result of
// the run. Once the last item is in, s_tready stays low while the block works
// on the n stored values: a count pass and a rank pass, each of which scans
// the value store once per entry through the single compare unit (the store
// read port gives one entry per cycle, after a fetch state and a latch state
// that fetch and hold the entry being counted or ranked). The results then
// leave on the master side in order of rising occurrence count, ties broken
// by smaller signed value; each passes through a read, a load and a wait
// state, and the next is read only once m_tready has taken the held one.
// No memory needs clearing after reset.
module frequency_sort_engine_core #(
    parameter int MAX_ITEMS = fse_pkg::MAX_ITEMS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // slave side
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [fse_pkg::VALUE_W-1:0] s_tdata,   // [31:0] item_value
    input  logic                        s_tlast,   // item_last
    // master side
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [fse_pkg::VALUE_W-1:0] m_tdata,   // [31:0] sorted_value
    output logic                        m_tlast,   // sorted_last
    output logic [0:0]                  m_tuser    // [0] dropped_flag
);

    localparam int AW = $clog2(MAX_ITEMS);      // store address width
    localparam int CW = $clog2(MAX_ITEMS + 1);  // counts up to MAX_ITEMS

    // Sequencer state and counters
    fse_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   fill_reg, fill_next;       // stored items, also n
    logic            ovf_reg, ovf_next;         // an item was dropped
    logic [AW-1:0]   i_reg, i_next;             // entry being counted/ranked
    logic [CW-1:0]   j_reg, j_next;             // next scan address to issue
    logic [AW-1:0]   jd_reg, jd_next;           // entry whose data is on rdata
    logic [CW-1:0]   acc_reg, acc_next;         // running count or rank
    logic [AW-1:0]   k_reg, k_next;             // emit index

    // Held entry
    logic [fse_pkg::VALUE_W-1:0] hold_val_reg, hold_val_next;
    logic [CW-1:0]               hold_cnt_reg, hold_cnt_next;

    // Output register
    logic                        out_valid_reg, out_valid_next;
    logic [fse_pkg::VALUE_W-1:0] out_data_reg, out_data_next;
    logic                        out_last_reg, out_last_next;
    logic                        out_drop_reg, out_drop_next;

    // Memory ports
    logic                        val_we;
    logic [AW-1:0]               val_waddr;
    logic [AW-1:0]               scan_raddr;
    logic [fse_pkg::VALUE_W-1:0] val_rdata;
    logic                        cnt_we;
    logic [CW-1:0]               cnt_wdata;
    logic [CW-1:0]               cnt_rdata;
    logic                        srt_we;
    logic [AW-1:0]               srt_waddr;
    logic [fse_pkg::VALUE_W-1:0] srt_rdata;

    fse_pkg::cmp_t cmp_res;
    logic          s_accept;
    logic          full;
    logic          incr;
    logic [CW-1:0] acc_sum;
    logic          i_done;

    // Value store: written while loading, scanned in both passes.
    fse_ram #(
        .WIDTH (fse_pkg::VALUE_W),
        .DEPTH (MAX_ITEMS)
    ) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (s_tdata),
        .raddr (scan_raddr),
        .rdata (val_rdata)
    );

    // Occurrence store: written in the count pass, scanned in the rank pass.
    fse_ram #(
        .WIDTH (CW),
        .DEPTH (MAX_ITEMS)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (i_reg),
        .wdata (cnt_wdata),
        .raddr (scan_raddr),
        .rdata (cnt_rdata)
    );

    // Sorted store: each value lands at its rank, then is read out in order.
    fse_ram #(
        .WIDTH (fse_pkg::VALUE_W),
        .DEPTH (MAX_ITEMS)
    ) u_srt_ram (
        .clk   (clk),
        .we    (srt_we),
        .waddr (srt_waddr),
        .wdata (hold_val_reg),
        .raddr (k_reg),
        .rdata (srt_rdata)
    );

    // Compare the scanned entry (on the read data) against the held entry.
    fse_cmp #(
        .CNT_W (CW)
    ) u_cmp (
        .scan_val (val_rdata),
        .scan_cnt (cnt_rdata),
        .held_val (hold_val_reg),
        .held_cnt (hold_cnt_reg),
        .result   (cmp_res)
    );

    assign s_tready  = (state_reg == fse_pkg::ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign full      = (fill_reg == CW'(MAX_ITEMS));
    assign val_we    = s_accept && !full;
    assign val_waddr = fill_reg[AW-1:0];
    assign acc_sum   = acc_reg + CW'(incr);
    assign cnt_wdata = acc_sum;
    assign srt_waddr = acc_sum[AW-1:0];
    assign i_done    = (CW'(i_reg) + CW'(1)) == fill_reg;

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tlast    = out_last_reg;
    assign m_tuser[0] = out_drop_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fse_pkg::ST_IDLE;
            fill_reg      <= '0;
            ovf_reg       <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            jd_reg        <= '0;
            acc_reg       <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            ovf_reg       <= ovf_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            jd_reg        <= jd_next;
            acc_reg       <= acc_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_val_reg <= hold_val_next;
        hold_cnt_reg <= hold_cnt_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_drop_reg <= out_drop_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        ovf_next       = ovf_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        jd_next        = jd_reg;
        acc_next       = acc_reg;
        k_next         = k_reg;
        hold_val_next  = hold_val_reg;
        hold_cnt_next  = hold_cnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_drop_next  = out_drop_reg;
        scan_raddr     = j_reg[AW-1:0];
        cnt_we         = 1'b0;
        srt_we         = 1'b0;
        incr           = 1'b0;

        unique case (state_reg)
            fse_pkg::ST_IDLE:
            begin
                // Store the item, or drop it and remember the overflow.
                if (s_accept)
                begin
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        fill_next = fill_reg + CW'(1);
                    end
                    if (s_tlast)
                    begin
                        i_next     = '0;
                        state_next = fse_pkg::ST_CNT_FETCH;
                    end
                end
            end

            fse_pkg::ST_CNT_FETCH:
            begin
                scan_raddr = i_reg;
                state_next = fse_pkg::ST_CNT_LATCH;
            end

            fse_pkg::ST_CNT_LATCH:
            begin
                // Hold entry i and issue the first scan read.
                hold_val_next = val_rdata;
                scan_raddr    = '0;
                j_next        = CW'(1);
                jd_next       = '0;
                acc_next      = '0;
                state_next    = fse_pkg::ST_CNT_SCAN;
            end

            fse_pkg::ST_CNT_SCAN:
            begin
                incr = cmp_res.val_eq;
                if (j_reg != fill_reg)
                begin
                    acc_next = acc_sum;
                    jd_next  = j_reg[AW-1:0];
                    j_next   = j_reg + CW'(1);
                end
                else
                begin
                    // Last compare done: write the occurrence count.
                    cnt_we = 1'b1;
                    if (i_done)
                    begin
                        i_next     = '0;
                        state_next = fse_pkg::ST_RNK_FETCH;
                    end
                    else
                    begin
                        i_next     = i_reg + AW'(1);
                        state_next = fse_pkg::ST_CNT_FETCH;
                    end
                end
            end

            fse_pkg::ST_RNK_FETCH:
            begin
                scan_raddr = i_reg;
                state_next = fse_pkg::ST_RNK_LATCH;
            end

            fse_pkg::ST_RNK_LATCH:
            begin
                hold_val_next = val_rdata;
                hold_cnt_next = cnt_rdata;
                scan_raddr    = '0;
                j_next        = CW'(1);
                jd_next       = '0;
                acc_next      = '0;
                state_next    = fse_pkg::ST_RNK_SCAN;
            end

            fse_pkg::ST_RNK_SCAN:
            begin
                // Rank counts strictly smaller keys, plus equal ones stored earlier.
                incr = cmp_res.scan_first || (cmp_res.val_eq && (jd_reg < i_reg));
                if (j_reg != fill_reg)
                begin
                    acc_next = acc_sum;
                    jd_next  = j_reg[AW-1:0];
                    j_next   = j_reg + CW'(1);
                end
                else
                begin
                    srt_we = 1'b1;
                    if (i_done)
                    begin
                        k_next     = '0;
                        state_next = fse_pkg::ST_EMIT_READ;
                    end
                    else
                    begin
                        i_next     = i_reg + AW'(1);
                        state_next = fse_pkg::ST_RNK_FETCH;
                    end
                end
            end

            fse_pkg::ST_EMIT_READ:
            begin
                state_next = fse_pkg::ST_EMIT_LOAD;
            end

            fse_pkg::ST_EMIT_LOAD:
            begin
                out_valid_next = 1'b1;
                out_data_next  = srt_rdata;
                out_last_next  = (CW'(k_reg) + CW'(1)) == fill_reg;
                out_drop_next  = ovf_reg;
                state_next     = fse_pkg::ST_EMIT_WAIT;
            end

            fse_pkg::ST_EMIT_WAIT:
            begin
                // Hold the result until taken; after the final one, empty the store.
                if (m_tready)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        fill_next  = '0;
                        ovf_next   = 1'b0;
                        state_next = fse_pkg::ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + AW'(1);
                        state_next = fse_pkg::ST_EMIT_READ;
                    end
                end
            end

            default:
            begin
                state_next = fse_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* src/fse_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module fse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/fse_cmp.sv */
// Shared key compare unit of the frequency sort engine: orders entries by
// occurrence count, then by signed value. Depends on fse_pkg.
module fse_cmp #(
    parameter int CNT_W = 7
) (
    input  logic [fse_pkg::VALUE_W-1:0] scan_val,
    input  logic [CNT_W-1:0]            scan_cnt,
    input  logic [fse_pkg::VALUE_W-1:0] held_val,
    input  logic [CNT_W-1:0]            held_cnt,
    output fse_pkg::cmp_t               result
);

    logic val_lt;
    logic cnt_lt;
    logic cnt_eq;

    always_comb
    begin
        val_lt            = $signed(scan_val) < $signed(held_val);
        cnt_lt            = scan_cnt < held_cnt;
        cnt_eq            = scan_cnt == held_cnt;
        result.val_eq     = scan_val == held_val;
        result.scan_first = cnt_lt || (cnt_eq && val_lt);
    end

endmodule

/* tb/sv/frequency_sort_engine_core_tb.sv */
// Self-checking testbench for frequency_sort_engine_core: streams value runs in,
// predicts the frequency-then-value order and checks every result item.
// Depends on fse_pkg and the frequency_sort_engine_core RTL.
module frequency_sort_engine_core_tb;

    localparam int VALUE_W       = fse_pkg::VALUE_W;
    localparam int CAPACITY      = fse_pkg::MAX_ITEMS_DEF;
    localparam int RANDOM_ITEMS  = 500;
    localparam int QUIET_AFTER   = 420;     // no idling once this many random items went in
    localparam int STALL_LIMIT   = 40000;   // longest gap with no handshake before the watchdog ends the run
    localparam int DRAIN_CYCLES  = 20;

    // One expected result item.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
        logic               dropped;
    } sorted_word_t;

    // Keeps its own copy of the store and predicts each run's output order.
    class sort_scoreboard;
        int                 capacity;
        logic [VALUE_W-1:0] loaded[$];
        bit                 overflow;
        sorted_word_t       expected_q[$];
        int                 errors;

        function new(int cap);
            capacity = cap;
            overflow = 0;
            errors   = 0;
        endfunction

        // Store or drop one accepted item; on the last item, rank the run.
        function void note_item(logic [VALUE_W-1:0] value, logic last);
            int hits[$];
            int order[$];
            int j;
            int cnt;
            if (loaded.size() < capacity)
                loaded.push_back(value);
            else
                overflow = 1;
            if (!last)
                return;
            foreach (loaded[i]) begin
                cnt = 0;
                foreach (loaded[k])
                    if (loaded[k] == loaded[i])
                        cnt++;
                hits.push_back(cnt);
            end
            // insertion sort: rarer first, then smaller signed value
            foreach (loaded[i]) begin
                j = order.size();
                order.push_back(i);
                while (j > 0 && (hits[i] < hits[order[j-1]] ||
                                 (hits[i] == hits[order[j-1]] &&
                                  $signed(loaded[i]) < $signed(loaded[order[j-1]])))) begin
                    order[j] = order[j-1];
                    j--;
                end
                order[j] = i;
            end
            foreach (order[p])
                expected_q.push_back('{loaded[order[p]], p == order.size() - 1, overflow});
            loaded.delete();
            overflow = 0;
        endfunction

        // Compare one accepted result item against the oldest expectation.
        function void check_result(logic [VALUE_W-1:0] value, logic last, logic dropped);
            sorted_word_t want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual value %h last %b dropped %b",
                         $time, value, last, dropped);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (value !== want.value) begin
                $display("%0t: sorted_value mismatch, expected %h, actual %h",
                         $time, want.value, value);
                errors++;
            end
            if (last !== want.last) begin
                $display("%0t: sorted_last mismatch, expected %b, actual %b",
                         $time, want.last, last);
                errors++;
            end
            if (dropped !== want.dropped) begin
                $display("%0t: dropped_flag mismatch, expected %b, actual %b",
                         $time, want.dropped, dropped);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [VALUE_W-1:0] s_tdata  = '0;
    logic               s_tlast  = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [VALUE_W-1:0] m_tdata;
    logic               m_tlast;
    logic [0:0]         m_tuser;

    sort_scoreboard sb = new(CAPACITY);
    bit             idling_on = 1'b1;
    int             idle_cycles = 0;

    frequency_sort_engine_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Sample both handshakes at the edge; check results before noting inputs.
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tlast, m_tuser[0]);
        if (s_tvalid && s_tready)
            sb.note_item(s_tdata, s_tlast);
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no item accepted for %0d cycles", $time, idle_cycles);
                $display("frequency_sort_engine_core test failed");
                $finish;
            end
        end
    end

    // Receiver: while idling is on, drop m_tready now and then at random; else keep it high.
    initial
    begin
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (idling_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                m_tready <= 1'b1;
            end else if ($urandom_range(0, 9) == 0) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(20, 60)) @(posedge clk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Present one item, maybe after a gap, and hold it until accepted.
    task automatic send_item(logic [VALUE_W-1:0] value, logic last);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
    endtask

    // Hold off the sender until every expected result has come out; first wait
    // for a clock edge so the monitor has noted the item accepted at this edge.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Send len values from a pool of 1 to 6 (at times len) values so that repeats occur.
    task automatic send_run(int len, output int sent);
        logic [VALUE_W-1:0] pool[$];
        int                 pool_size;
        pool_size = ($urandom_range(0, 4) == 0) ? len : $urandom_range(1, 6);
        for (int i = 0; i < pool_size; i++) begin
            case ($urandom_range(0, 9))
                0:       pool.push_back(32'h8000_0000);
                1:       pool.push_back(32'h7fff_ffff);
                2:       pool.push_back(32'hffff_ffff);
                3:       pool.push_back(32'h0000_0000);
                default: pool.push_back($urandom());
            endcase
        end
        for (int i = 0; i < len; i++)
            send_item(pool[$urandom_range(0, pool_size - 1)], i == len - 1);
        sent = len;
    endtask

    initial
    begin
        logic [VALUE_W-1:0] mixed[];
        logic [VALUE_W-1:0] falling[];
        int total;
        int sent;

        mixed   = '{32'd5, 32'hffff_ffff, 32'd5, 32'h7fff_ffff,
                    32'h8000_0000, 32'hffff_ffff, 32'd5, 32'd0, 32'd1};
        falling = '{32'd3, 32'd2, 32'd1, 32'hffff_ffff};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: single-item runs at both extremes.
        send_item(32'h8000_0000, 1'b1);
        send_item(32'h7fff_ffff, 1'b1);
        // Mixed counts with ties across sign boundaries.
        foreach (mixed[i])
            send_item(mixed[i], i == mixed.size() - 1);
        // All copies of one value.
        repeat (2) send_item(32'hffff_ffff, 1'b0);
        send_item(32'hffff_ffff, 1'b1);
        // Distinct values, arriving in falling order.
        foreach (falling[i])
            send_item(falling[i], i == falling.size() - 1);
        wait_for_results();

        // Capacity: exactly full, then overflow with the last two items dropped.
        total = 0;
        send_run(CAPACITY, sent);
        total += sent;
        send_run(CAPACITY + 2, sent);
        total += sent;

        // Random runs, mostly short, now and then a longer one.
        while (total < RANDOM_ITEMS) begin
            if (total >= QUIET_AFTER)
                idling_on = 1'b0;
            send_run(($urandom_range(0, 7) == 0) ? $urandom_range(13, 24)
                                                 : $urandom_range(1, 12), sent);
            total += sent;
            if ($urandom_range(0, 7) == 0)
                wait_for_results();
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("frequency_sort_engine_core test passed");
        else
            $display("frequency_sort_engine_core test failed");
        $finish;
    end

endmodule

/* filelist.f */
src/fse_pkg.sv
src/fse_ram.sv
src/fse_cmp.sv
src/frequency_sort_engine_core.sv
tb/sv/frequency_sort_engine_core_tb.sv
